// ===== rtl/ibtt_pkg.sv =====
// Shared types and constants of the IoU box track table.
// No dependencies; all other files bar the checker use it by scoped names.
`default_nettype none

package ibtt_pkg;

    // match count width and its limits
    localparam int unsigned CNT_W = 8;
    localparam logic [CNT_W-1:0] MAX_COUNT_RST = 8'd10;
    localparam logic [CNT_W-1:0] COUNT_STEP    = 8'd2;
    localparam logic [CNT_W-1:0] NEW_COUNT     = 8'd1;

    // IoU above 0.2 means 5 * intersection above union
    localparam int unsigned IOU_RATIO = 5;

    // request codes
    localparam logic REQ_OBS  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // register stages in the IoU unit, and the width of the drain counter
    localparam int unsigned IOU_LAT = 3;
    localparam int unsigned LAT_W   = 2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    // per-cell control, driven by the sequencer
    typedef struct packed {
        logic shift;   // take box and count from the next cell in the ring
        logic decay;   // decrement a nonzero count
        logic wr;      // load the write box and count
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== rtl/iou_box_track_table.sv =====
// IoU box track table: top level with sequencer, cell ring and IoU unit.
// Depends on ibtt_pkg, ibtt_cell and ibtt_iou.
//
// Usage
//   Input: drive the request fields and raise start; the item transfers at a
//   rising edge with start high and busy low. A frame tick (i_req_type = 1)
//   decays every nonzero count at that edge, gives no result and leaves busy
//   low. A box observation raises busy while the ring of cells rotates once
//   past the IoU unit (one entry per cycle) and the three-stage IoU pipeline
//   drains; then the matched or new cell is written, none for a dropped box.
//   Output: one result per observation, on the o_ ports for exactly one cycle
//   with o_result_stb high, registered from the final sequencer state. The
//   receiver cannot hold it off; busy is already low in that cycle, so the
//   next item may transfer then. No new observation is taken before the last
//   one has its result; the one-entry-per-cycle ring rotation sets the pace.
//   Configuration: i_cfg_we with i_cfg_data writes the count limit; write
//   only while busy is low.
//   Reset: synchronous, active low; clears the entry count, all match counts
//   and the control state, and sets the count limit to 10.
`default_nettype none

module iou_box_track_table #(
    parameter int ENTRIES    = 16,
    parameter int COORD_BITS = 12
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                i_req_type,
    input  wire logic [COORD_BITS-1:0]               i_box_left,
    input  wire logic [COORD_BITS-1:0]               i_box_top,
    input  wire logic [COORD_BITS-1:0]               i_box_right,
    input  wire logic [COORD_BITS-1:0]               i_box_bottom,
    input  wire logic                                i_cfg_we,
    input  wire logic [ibtt_pkg::CNT_W-1:0]          i_cfg_data,
    output logic                                     o_result_stb,
    output logic [$clog2(ENTRIES+1)-1:0]             o_entry_id,
    output logic                                     o_is_new,
    output logic                                     o_table_full,
    output logic [ibtt_pkg::CNT_W-1:0]               o_match_count
);

    localparam int CNT_W = ibtt_pkg::CNT_W;
    localparam int BOX_W = 4 * COORD_BITS;
    localparam int ID_W  = $clog2(ENTRIES + 1);
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int LAT_W = ibtt_pkg::LAT_W;

    ibtt_pkg::t_state r_state, n_state;
    logic [IDX_W-1:0] r_scan_idx, n_scan_idx;
    logic [LAT_W-1:0] r_drain, n_drain;
    logic [ID_W-1:0]  r_entry_count;
    logic [CNT_W-1:0] r_max_count;
    logic [BOX_W-1:0] r_new_box;

    logic             r_found;
    logic [IDX_W-1:0] r_match_idx;
    logic [CNT_W-1:0] r_match_cnt;

    logic             r_stb;
    logic [ID_W-1:0]  r_entry_id;
    logic             r_is_new;
    logic             r_table_full;
    logic [CNT_W-1:0] r_count_out;

    logic accept, tick_accept, obs_accept;
    logic shift, done, scan_valid, full, wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [CNT_W-1:0] wr_count;
    logic [CNT_W:0]   sum_count;
    logic [CNT_W-1:0] sat_count;

    logic [BOX_W-1:0] w_box [ENTRIES];
    logic [CNT_W-1:0] w_cnt [ENTRIES];

    logic             res_valid, res_match;
    logic [IDX_W-1:0] res_idx;
    logic [CNT_W-1:0] res_count;

    assign busy        = (r_state != ibtt_pkg::S_IDLE);
    assign accept      = start && !busy;
    assign tick_accept = accept && (i_req_type == ibtt_pkg::REQ_TICK);
    assign obs_accept  = accept && (i_req_type == ibtt_pkg::REQ_OBS);

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_scan_idx = r_scan_idx;
        n_drain    = r_drain;
        shift      = 1'b0;
        done       = 1'b0;
        unique case (r_state)
            ibtt_pkg::S_IDLE: begin
                n_scan_idx = '0;
                if (obs_accept) begin
                    n_state = ibtt_pkg::S_SCAN;
                end
            end
            ibtt_pkg::S_SCAN: begin
                shift      = 1'b1;
                n_scan_idx = r_scan_idx + IDX_W'(1);
                n_drain    = '0;
                if (r_scan_idx == IDX_W'(ENTRIES - 1)) begin
                    n_scan_idx = '0;
                    n_state    = ibtt_pkg::S_DRAIN;
                end
            end
            ibtt_pkg::S_DRAIN: begin
                n_drain = r_drain + LAT_W'(1);
                if (r_drain == LAT_W'(ibtt_pkg::IOU_LAT - 1)) begin
                    n_state = ibtt_pkg::S_DONE;
                end
            end
            ibtt_pkg::S_DONE: begin
                done    = 1'b1;
                n_state = ibtt_pkg::S_IDLE;
            end
            default: begin
                n_state = ibtt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ibtt_pkg::S_IDLE;
            r_scan_idx <= '0;
            r_drain    <= '0;
        end else begin
            r_state    <= n_state;
            r_scan_idx <= n_scan_idx;
            r_drain    <= n_drain;
        end
    end

    // only filled entries take part in the scan
    assign scan_valid = (r_state == ibtt_pkg::S_SCAN)
                        && (ID_W'(r_scan_idx) < r_entry_count);

    // update decision
    assign full      = (r_entry_count >= ID_W'(ENTRIES));
    assign sum_count = {1'b0, r_match_cnt} + {1'b0, ibtt_pkg::COUNT_STEP};
    assign sat_count = (sum_count > {1'b0, r_max_count}) ? r_max_count
                                                          : sum_count[CNT_W-1:0];
    assign wr_en     = done && (r_found || !full);
    assign wr_idx    = r_found ? r_match_idx : r_entry_count[IDX_W-1:0];
    assign wr_count  = r_found ? sat_count : ibtt_pkg::NEW_COUNT;

    // ring of cells: cell k takes from cell k+1, cell 0 feeds the IoU unit
    for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
        localparam int NK = (k + 1) % ENTRIES;
        ibtt_pkg::t_cell_ctrl ctrl;

        always_comb begin
            ctrl.shift = shift;
            ctrl.decay = tick_accept;
            ctrl.wr    = wr_en && (wr_idx == IDX_W'(k));
        end

        ibtt_cell #(
            .COORD_BITS (COORD_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (ctrl),
            .i_nbr_box   (w_box[NK]),
            .i_nbr_count (w_cnt[NK]),
            .i_wr_box    (r_new_box),
            .i_wr_count  (wr_count),
            .o_box       (w_box[k]),
            .o_count     (w_cnt[k])
        );
    end

    ibtt_iou #(
        .COORD_BITS (COORD_BITS),
        .IDX_W      (IDX_W)
    ) u_iou (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (scan_valid),
        .i_idx     (r_scan_idx),
        .i_count   (w_cnt[0]),
        .i_old_box (w_box[0]),
        .i_new_box (r_new_box),
        .o_valid   (res_valid),
        .o_match   (res_match),
        .o_idx     (res_idx),
        .o_count   (res_count)
    );

    // hold the observed box for the whole scan
    always_ff @(posedge i_clk) begin
        if (obs_accept) begin
            r_new_box <= {i_box_bottom, i_box_right, i_box_top, i_box_left};
        end
    end

    // keep the first match in table order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else begin
            priority if (obs_accept) begin
                r_found <= 1'b0;
            end else if (res_valid && res_match && !r_found) begin
                r_found <= 1'b1;
            end else begin
                r_found <= r_found;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_match && !r_found) begin
            r_match_idx <= res_idx;
            r_match_cnt <= res_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
            r_max_count   <= ibtt_pkg::MAX_COUNT_RST;
            r_stb         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_count <= i_cfg_data;
            end
            if (done && !r_found && !full) begin
                r_entry_count <= r_entry_count + ID_W'(1);
            end
            r_stb <= done;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (done) begin
            priority if (r_found) begin
                r_entry_id   <= ID_W'(r_match_idx) + ID_W'(1);
                r_is_new     <= 1'b0;
                r_table_full <= 1'b0;
                r_count_out  <= sat_count;
            end else if (full) begin
                r_entry_id   <= '0;
                r_is_new     <= 1'b0;
                r_table_full <= 1'b1;
                r_count_out  <= '0;
            end else begin
                r_entry_id   <= r_entry_count + ID_W'(1);
                r_is_new     <= 1'b1;
                r_table_full <= 1'b0;
                r_count_out  <= ibtt_pkg::NEW_COUNT;
            end
        end
    end

    assign o_result_stb  = r_stb;
    assign o_entry_id    = r_entry_id;
    assign o_is_new      = r_is_new;
    assign o_table_full  = r_table_full;
    assign o_match_count = r_count_out;

endmodule

`default_nettype wire

// ===== rtl/ibtt_cell.sv =====
// One table cell: a stored box and its match count, linked into a ring.
// Depends on ibtt_pkg for the count width and the control struct.
`default_nettype none

module ibtt_cell #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire ibtt_pkg::t_cell_ctrl          i_ctrl,
    input  wire logic [4*COORD_BITS-1:0]       i_nbr_box,
    input  wire logic [ibtt_pkg::CNT_W-1:0]    i_nbr_count,
    input  wire logic [4*COORD_BITS-1:0]       i_wr_box,
    input  wire logic [ibtt_pkg::CNT_W-1:0]    i_wr_count,
    output logic      [4*COORD_BITS-1:0]       o_box,
    output logic      [ibtt_pkg::CNT_W-1:0]    o_count
);

    logic [4*COORD_BITS-1:0]    r_box;
    logic [4*COORD_BITS-1:0]    n_box;
    logic [ibtt_pkg::CNT_W-1:0] r_count;
    logic [ibtt_pkg::CNT_W-1:0] n_count;

    always_comb begin
        n_box   = r_box;
        n_count = r_count;
        priority if (i_ctrl.wr) begin
            n_box   = i_wr_box;
            n_count = i_wr_count;
        end else if (i_ctrl.shift) begin
            n_box   = i_nbr_box;
            n_count = i_nbr_count;
        end else if (i_ctrl.decay && r_count != '0) begin
            n_count = r_count - ibtt_pkg::CNT_W'(1);
        end else begin
            // hold
            n_box   = r_box;
            n_count = r_count;
        end
    end

    // box needs no reset: an entry is only read once it has been written
    always_ff @(posedge i_clk) begin
        r_box <= n_box;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_box   = r_box;
    assign o_count = r_count;

endmodule

`default_nettype wire

// ===== rtl/ibtt_iou.sv =====
// Three-stage IoU test of a stored box against the new box: overlap and
// side lengths, then products, then union and ratio compare. Uses ibtt_pkg.
`default_nettype none

module ibtt_iou #(
    parameter int COORD_BITS = 12,
    parameter int IDX_W      = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic [IDX_W-1:0]              i_idx,
    input  wire logic [ibtt_pkg::CNT_W-1:0]    i_count,
    input  wire logic [4*COORD_BITS-1:0]       i_old_box,
    input  wire logic [4*COORD_BITS-1:0]       i_new_box,
    output logic                               o_valid,
    output logic                               o_match,
    output logic      [IDX_W-1:0]              o_idx,
    output logic      [ibtt_pkg::CNT_W-1:0]    o_count
);

    localparam int CW = COORD_BITS;
    localparam int SW = COORD_BITS + 1;       // signed difference
    localparam int PW = 2 * SW;               // signed product
    localparam int UW = 2 * SW + 2;           // union and scaled intersection

    logic [CW-1:0] a_l, a_t, a_r, a_b, b_l, b_t, b_r, b_b;
    logic [CW-1:0] min_r, max_l, min_b, max_t;
    logic signed [SW-1:0] n_w, n_h;

    assign a_l = i_old_box[CW-1:0];
    assign a_t = i_old_box[2*CW-1:CW];
    assign a_r = i_old_box[3*CW-1:2*CW];
    assign a_b = i_old_box[4*CW-1:3*CW];
    assign b_l = i_new_box[CW-1:0];
    assign b_t = i_new_box[2*CW-1:CW];
    assign b_r = i_new_box[3*CW-1:2*CW];
    assign b_b = i_new_box[4*CW-1:3*CW];

    assign min_r = (a_r < b_r) ? a_r : b_r;
    assign max_l = (a_l > b_l) ? a_l : b_l;
    assign min_b = (a_b < b_b) ? a_b : b_b;
    assign max_t = (a_t > b_t) ? a_t : b_t;
    assign n_w   = $signed({1'b0, min_r}) - $signed({1'b0, max_l});
    assign n_h   = $signed({1'b0, min_b}) - $signed({1'b0, max_t});

    // stage 1: clamped overlap sides and signed box sides
    logic [CW-1:0]        r_w, r_h;
    logic signed [SW-1:0] r_ax, r_ay, r_bx, r_by;
    // stage 2: products
    logic [2*CW-1:0]      r_inter;
    logic signed [PW-1:0] r_area_a, r_area_b;
    // stage 3: decision
    logic                 r_match;

    logic r_v1, r_v2, r_v3;
    logic [IDX_W-1:0] r_idx1, r_idx2, r_idx3;
    logic [ibtt_pkg::CNT_W-1:0] r_cnt1, r_cnt2, r_cnt3;

    logic signed [UW-1:0] n_uni, n_scaled, n_inter_x;
    logic                 n_match;

    always_comb begin
        n_inter_x = $signed(UW'(r_inter));
        n_uni     = UW'(r_area_a) + UW'(r_area_b) - n_inter_x;
        n_scaled  = $signed(UW'(ibtt_pkg::IOU_RATIO)) * n_inter_x;
        n_match   = !n_uni[UW-1] && (n_uni != '0) && (n_scaled > n_uni);
    end

    always_ff @(posedge i_clk) begin
        r_w  <= (!n_w[SW-1] && n_w != '0) ? n_w[CW-1:0] : '0;
        r_h  <= (!n_h[SW-1] && n_h != '0) ? n_h[CW-1:0] : '0;
        r_ax <= $signed({1'b0, a_r}) - $signed({1'b0, a_l});
        r_ay <= $signed({1'b0, a_b}) - $signed({1'b0, a_t});
        r_bx <= $signed({1'b0, b_r}) - $signed({1'b0, b_l});
        r_by <= $signed({1'b0, b_b}) - $signed({1'b0, b_t});

        r_inter  <= r_w * r_h;
        r_area_a <= r_ax * r_ay;
        r_area_b <= r_bx * r_by;

        r_match <= n_match;

        r_idx1 <= i_idx;
        r_idx2 <= r_idx1;
        r_idx3 <= r_idx2;
        r_cnt1 <= i_count;
        r_cnt2 <= r_cnt1;
        r_cnt3 <= r_cnt2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_valid = r_v3;
    assign o_match = r_match;
    assign o_idx   = r_idx3;
    assign o_count = r_cnt3;

endmodule

`default_nettype wire

// ===== rtl/ibtt_checker.sv =====
// Port-level checks of the IoU box track table, bound to the top level.
// Depends on iou_box_track_table only through its ports.
`default_nettype none

module ibtt_checker #(
    parameter int ID_W = 5
) (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            start,
    input wire logic            busy,
    input wire logic            i_req_type,
    input wire logic            o_result_stb,
    input wire logic [ID_W-1:0] o_entry_id,
    input wire logic            o_table_full
);

    // a frame tick completes at once
    a_tick_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req_type) |=> !busy)
        else $error("busy raised after a frame tick transfer");

    // an observation always starts a scan
    a_obs_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_req_type) |=> busy)
        else $error("busy not raised after an observation transfer");

    // a result only ends a scan
    a_stb_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_stb |-> $past(busy))
        else $error("result strobe without a preceding scan");

    a_stb_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_stb |=> !o_result_stb)
        else $error("result strobe held for more than one cycle");

    // dropped boxes carry id 0, all others a real id
    a_id_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_stb |-> ((o_table_full && o_entry_id == '0)
                          || (!o_table_full && o_entry_id != '0)))
        else $error("entry id disagrees with table full flag");

endmodule

bind iou_box_track_table ibtt_checker #(
    .ID_W (ID_W)
) u_ibtt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_req_type   (i_req_type),
    .o_result_stb (o_result_stb),
    .o_entry_id   (o_entry_id),
    .o_table_full (o_table_full)
);

`default_nettype wire

// ===== sim/tb_iou_box_track_table.sv =====
// Self-checking testbench for the IoU box track table: a directed pass, then
// random phases of observations and frame ticks under several count limits.
// Depends on ibtt_pkg and iou_box_track_table from the rtl folder.
`timescale 1ns / 100ps

module tb_iou_box_track_table;

    localparam int ENTRIES        = 16;
    localparam int COORD_BITS     = 12;
    localparam int ID_W           = $clog2(ENTRIES + 1);
    localparam int CNT_W          = ibtt_pkg::CNT_W;
    localparam int MAX_REPORTS    = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = ENTRIES + 8;

    typedef struct packed {
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] top;
        logic [COORD_BITS-1:0] right;
        logic [COORD_BITS-1:0] bottom;
    } t_box;

    typedef struct packed {
        logic req_type;
        t_box box;
    } t_track_req;

    typedef struct packed {
        logic [ID_W-1:0]  entry_id;
        logic             is_new;
        logic             table_full;
        logic [CNT_W-1:0] match_count;
    } t_track_result;

    // Mirrors the track table and queues the result each observation should give.
    class track_table_sb;
        logic [CNT_W-1:0] count_limit;
        int unsigned      n_entries;
        t_box             boxes [ENTRIES];
        logic [CNT_W-1:0] counts [ENTRIES];
        t_track_result    expected_results [$];
        int unsigned      errors;

        function new();
            count_limit = ibtt_pkg::MAX_COUNT_RST;
            n_entries   = 0;
            errors      = 0;
            foreach (counts[i]) counts[i] = '0;
        endfunction

        function void set_limit(logic [CNT_W-1:0] value);
            count_limit = value;
        endfunction

        // 5 * intersection above a positive union, corners taken as signed spans
        function bit iou_above(t_box s, t_box n);
            longint sl, st, sr, sb, nl, nt, nr, nb;
            longint w, h, inter, uni;
            sl = s.left;  st = s.top;  sr = s.right;  sb = s.bottom;
            nl = n.left;  nt = n.top;  nr = n.right;  nb = n.bottom;
            w = ((sr < nr) ? sr : nr) - ((sl > nl) ? sl : nl);
            h = ((sb < nb) ? sb : nb) - ((st > nt) ? st : nt);
            inter = ((w > 0) ? w : 0) * ((h > 0) ? h : 0);
            uni = (sr - sl) * (sb - st) + (nr - nl) * (nb - nt) - inter;
            return (uni > 0) && (longint'(ibtt_pkg::IOU_RATIO) * inter > uni);
        endfunction

        function void note_transfer(t_track_req it);
            int unsigned   i;
            int unsigned   c;
            t_track_result res;
            if (it.req_type == ibtt_pkg::REQ_TICK) begin
                for (i = 0; i < n_entries; i++)
                    if (counts[i] != 0) counts[i] = counts[i] - 1'b1;
                return;
            end
            for (i = 0; i < n_entries; i++) begin
                if (iou_above(boxes[i], it.box)) begin
                    c = int'(counts[i]) + int'(ibtt_pkg::COUNT_STEP);
                    if (c > count_limit) c = count_limit;
                    boxes[i]  = it.box;
                    counts[i] = c[CNT_W-1:0];
                    res = '{entry_id: ID_W'(i + 1), is_new: 1'b0, table_full: 1'b0,
                            match_count: c[CNT_W-1:0]};
                    expected_results.insert(expected_results.size(), res);
                    return;
                end
            end
            if (n_entries >= ENTRIES) begin
                // drop the box
                res = '{entry_id: '0, is_new: 1'b0, table_full: 1'b1, match_count: '0};
            end else begin
                boxes[n_entries]  = it.box;
                counts[n_entries] = ibtt_pkg::NEW_COUNT;
                n_entries++;
                res = '{entry_id: ID_W'(n_entries), is_new: 1'b1, table_full: 1'b0,
                        match_count: ibtt_pkg::NEW_COUNT};
            end
            expected_results.insert(expected_results.size(), res);
        endfunction

        function void check_result(t_track_result got);
            t_track_result want;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected result: id %0d new %b full %b count %0d",
                             got.entry_id, got.is_new, got.table_full, got.match_count);
                return;
            end
            want = expected_results.pop_front();
            if (got.entry_id !== want.entry_id || got.is_new !== want.is_new ||
                got.table_full !== want.table_full || got.match_count !== want.match_count) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("mismatch: expected id %0d new %b full %b count %0d, %s%0d %s%b %s%b %s%0d",
                             want.entry_id, want.is_new, want.table_full, want.match_count,
                             "got id ", got.entry_id, "new ", got.is_new,
                             "full ", got.table_full, "count ", got.match_count);
            end
        endfunction
    endclass

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  start        = 1'b0;
    logic                  busy;
    logic                  i_req_type   = 1'b0;
    logic [COORD_BITS-1:0] i_box_left   = '0;
    logic [COORD_BITS-1:0] i_box_top    = '0;
    logic [COORD_BITS-1:0] i_box_right  = '0;
    logic [COORD_BITS-1:0] i_box_bottom = '0;
    logic                  i_cfg_we     = 1'b0;
    logic [CNT_W-1:0]      i_cfg_data   = '0;
    logic                  o_result_stb;
    logic [ID_W-1:0]       o_entry_id;
    logic                  o_is_new;
    logic                  o_table_full;
    logic [CNT_W-1:0]      o_match_count;

    track_table_sb sb = new();
    int            burst_left = 0;
    int            idle_cycles = 0;

    iou_box_track_table #(
        .ENTRIES    (ENTRIES),
        .COORD_BITS (COORD_BITS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req_type    (i_req_type),
        .i_box_left    (i_box_left),
        .i_box_top     (i_box_top),
        .i_box_right   (i_box_right),
        .i_box_bottom  (i_box_bottom),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .o_result_stb  (o_result_stb),
        .o_entry_id    (o_entry_id),
        .o_is_new      (o_is_new),
        .o_table_full  (o_table_full),
        .o_match_count (o_match_count)
    );

    always #2 i_clk = ~i_clk;

    // check results and watch for a stalled run
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else begin
            if (o_result_stb === 1'b1)
                sb.check_result('{entry_id: o_entry_id, is_new: o_is_new,
                                  table_full: o_table_full, match_count: o_match_count});
            if ((start && !busy) || o_result_stb === 1'b1) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
    end

    task automatic send_item(input t_track_req it);
        start        <= 1'b1;
        i_req_type   <= it.req_type;
        i_box_left   <= it.box.left;
        i_box_top    <= it.box.top;
        i_box_right  <= it.box.right;
        i_box_bottom <= it.box.bottom;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_transfer(it);
    endtask

    task automatic send_obs(input int l, input int t, input int r, input int b);
        send_item('{req_type: ibtt_pkg::REQ_OBS,
                    box: '{COORD_BITS'(l), COORD_BITS'(t), COORD_BITS'(r), COORD_BITS'(b)}});
    endtask

    task automatic send_tick();
        send_item('{req_type: ibtt_pkg::REQ_TICK,
                    box: '{COORD_BITS'($urandom), COORD_BITS'($urandom),
                           COORD_BITS'($urandom), COORD_BITS'($urandom)}});
    endtask

    // drop start for a gap set by n, with junk on the fields
    task automatic idle_gap(input int n);
        if (n > 0) begin
            start        <= 1'b0;
            i_req_type   <= 1'($urandom);
            i_box_left   <= COORD_BITS'($urandom);
            i_box_top    <= COORD_BITS'($urandom);
            i_box_right  <= COORD_BITS'($urandom);
            i_box_bottom <= COORD_BITS'($urandom);
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic pace();
        if (burst_left == 0) begin
            idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30));
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    // wait for every result, let the block settle, then write the limit
    task automatic write_limit(input int value);
        start <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= CNT_W'(value);
        @(posedge i_clk);
        sb.set_limit(CNT_W'(value));
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [COORD_BITS-1:0] nudge(logic [COORD_BITS-1:0] v, int spread);
        int x;
        x = int'(v) + $urandom_range(0, 2 * spread) - spread;
        if (x < 0) x = 0;
        if (x > (1 << COORD_BITS) - 1) x = (1 << COORD_BITS) - 1;
        return COORD_BITS'(x);
    endfunction

    function automatic t_box random_box(int hot);
        t_box b;
        int   pick;
        int   spread;
        int   idx;
        pick = $urandom_range(0, 99);
        if (sb.n_entries != 0 && pick < 60) begin
            // near a stored box, so most of these match
            idx = ($urandom_range(0, 1) == 0) ? hot : $urandom_range(0, sb.n_entries - 1);
            idx = idx % sb.n_entries;
            case ($urandom_range(0, 2))
                0: begin
                    spread = 3;
                end
                1: begin
                    spread = 25;
                end
                default: begin
                    spread = 300;
                end
            endcase
            b        = sb.boxes[idx];
            b.left   = nudge(b.left, spread);
            b.top    = nudge(b.top, spread);
            b.right  = nudge(b.right, spread);
            b.bottom = nudge(b.bottom, spread);
        end else if (pick < 85) begin
            b = '{COORD_BITS'($urandom), COORD_BITS'($urandom),
                  COORD_BITS'($urandom), COORD_BITS'($urandom)};
        end else if (pick < 95) begin
            // swapped or flat corners
            b.left   = COORD_BITS'($urandom);
            b.top    = COORD_BITS'($urandom);
            b.right  = COORD_BITS'($urandom_range(0, b.left));
            b.bottom = ($urandom_range(0, 1) == 0) ? COORD_BITS'($urandom_range(0, b.top))
                                                   : COORD_BITS'($urandom);
        end else begin
            b.left   = ($urandom_range(0, 1) == 0) ? '0 : '1;
            b.top    = ($urandom_range(0, 1) == 0) ? '0 : '1;
            b.right  = ($urandom_range(0, 1) == 0) ? '0 : '1;
            b.bottom = ($urandom_range(0, 1) == 0) ? '0 : '1;
        end
        return b;
    endfunction

    initial begin
        int limits [6];
        int phase_items [6];
        int lim;
        int hot;
        int tick_pct;
        limits      = '{255, 1, 0, 10, 3, 0};
        phase_items = '{400, 150, 150, 250, 200, 300};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed pass at the reset limit
        send_obs(0, 0, 4095, 4095);
        send_obs(0, 0, 4095, 4095);
        send_obs(4095, 4095, 0, 0);
        send_obs(100, 0, 0, 100);
        send_obs(5, 5, 5, 5);
        send_obs(5, 5, 5, 5);        // zero union against the flat entry: new entry
        send_obs(0, 0, 100, 100);
        send_obs(70, 0, 170, 100);
        send_obs(35, 0, 135, 100);   // overlaps two entries: the first one takes it
        send_tick();
        for (int k = 0; k < ENTRIES - 7; k++)
            send_obs(200 * k + 300, 3000, 200 * k + 350, 3050);
        send_obs(3900, 3900, 3950, 3950);    // table full: dropped
        send_obs(4095, 4095, 4095, 4095);
        send_tick();
        send_obs(72, 2, 171, 99);

        for (int p = 0; p < 6; p++) begin
            lim = (p == 5) ? $urandom_range(2, 254) : limits[p];
            write_limit(lim);
            hot      = $urandom_range(0, ENTRIES - 1);
            tick_pct = (p == 0) ? 8 : $urandom_range(10, 35);
            for (int n = 0; n < phase_items[p]; n++) begin
                pace();
                if ($urandom_range(0, 99) < tick_pct)
                    send_tick();
                else
                    send_item('{req_type: ibtt_pkg::REQ_OBS, box: random_box(hot)});
            end
        end

        start <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        sb.errors += sb.expected_results.size();
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== iou_box_track_table.f =====
rtl/ibtt_pkg.sv
rtl/ibtt_cell.sv
rtl/ibtt_iou.sv
rtl/iou_box_track_table.sv
rtl/ibtt_checker.sv
sim/tb_iou_box_track_table.sv
